FILE: rtl/mva_pkg.sv
// Package for the MIDI voice allocator: constants, codes and slot types.
// No dependencies.
`default_nettype none
package mva_pkg;
  localparam int unsigned NumVoices   = 8;
  localparam int unsigned NumChannels = 16;
  localparam int unsigned VoiceW      = $clog2(NumVoices);
  localparam int unsigned CntW        = $clog2(NumVoices + 1);
  localparam int unsigned MaxActive   = (NumVoices < 8) ? NumVoices : 8;

  localparam logic [1:0] SrcUnused = 2'd0;
  localparam logic [1:0] SrcMidi   = 2'd1;
  localparam logic [1:0] SrcCv     = 2'd2;

  localparam logic [1:0] KindMidi   = 2'd0;
  localparam logic [1:0] KindGate   = 2'd1;
  localparam logic [1:0] KindFinish = 2'd2;

  localparam logic [3:0] MsgNoteOff  = 4'h8;
  localparam logic [3:0] MsgNoteOn   = 4'h9;
  localparam logic [3:0] MsgPoly     = 4'ha;
  localparam logic [3:0] MsgCtrl     = 4'hb;
  localparam logic [3:0] MsgChanPres = 4'hd;
  localparam logic [3:0] MsgBend     = 4'he;

  localparam logic [6:0]  CtrlWheel   = 7'd1;
  localparam logic [6:0]  CtrlSustain = 7'd64;
  localparam logic [13:0] BendCentre  = 14'd8192;

  localparam logic       RegChanSel = 1'b0;
  localparam logic       RegVoices  = 1'b1;

  typedef struct packed {
    logic [1:0]  source;
    logic        gate;
    logic        key_held;
    logic [31:0] age;
    logic [6:0]  note;
    logic [3:0]  channel;
    logic [6:0]  velocity;
    logic [6:0]  poly;
  } slot_t;

  // operation broadcast to every cell for one pass
  typedef enum logic [3:0] {
    OP_NONE, OP_NOTE_OFF, OP_POLY, OP_SUS_REL, OP_CV_RISE, OP_CV_FALL,
    OP_CLEAR, OP_START
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [VoiceW-1:0] target;
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [6:0]  data;
    logic        sustain;
    logic [31:0] age;
  } cmd_t;
endpackage
`default_nettype wire

FILE: rtl/mva_cell.sv
// One voice slot cell: holds the slot, applies commands, and joins the
// oldest-candidate search chain. Depends on mva_pkg.
`default_nettype none
module mva_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [mva_pkg::VoiceW-1:0] idx_i,
  input  logic                      active_i,
  input  mva_pkg::cmd_t             cmd_i,
  input  logic                      apply_i,
  input  logic [1:0]                mode_i,
  input  logic                      found_i,
  input  logic [31:0]               best_age_i,
  input  logic [mva_pkg::VoiceW-1:0] best_idx_i,
  input  logic [mva_pkg::CntW-1:0]  rank_i,
  output logic                      found_o,
  output logic [31:0]               best_age_o,
  output logic [mva_pkg::VoiceW-1:0] best_idx_o,
  output logic [mva_pkg::CntW-1:0]  rank_o,
  output mva_pkg::slot_t            slot_o,
  output logic                      started_o
);
  import mva_pkg::*;
  slot_t slot_q, slot_d;
  logic  ok, hit, match, cv_ok;

  assign match = slot_q.source == SrcMidi && slot_q.channel == cmd_i.channel
                 && slot_q.note == cmd_i.note;

  // count of CV-restart candidates below and including this slot
  assign cv_ok  = active_i && !(slot_q.source == SrcMidi && slot_q.gate);
  assign rank_o = rank_i + CntW'(cv_ok);

  always_comb begin
    unique case (mode_i)
      2'd0: ok = !slot_q.gate;
      2'd1: ok = slot_q.source == SrcMidi && !slot_q.key_held;
      2'd2: ok = slot_q.source == SrcCv;
      default: ok = slot_q.gate;
    endcase
    hit = active_i && ok && (!found_i || slot_q.age < best_age_i);
    found_o    = found_i || hit;
    best_age_o = hit ? slot_q.age : best_age_i;
    best_idx_o = hit ? idx_i : best_idx_i;
  end

  always_comb begin
    slot_d    = slot_q;
    started_o = 1'b0;
    if (apply_i && active_i) begin
      unique case (cmd_i.op)
        OP_NOTE_OFF: if (match) begin
          slot_d.key_held = 1'b0;
          if (!cmd_i.sustain) slot_d.gate = 1'b0;
        end
        OP_POLY: if (match) slot_d.poly = cmd_i.data;
        OP_SUS_REL: if (slot_q.source == SrcMidi && slot_q.channel == cmd_i.channel
                        && !slot_q.key_held) slot_d.gate = 1'b0;
        OP_CV_RISE: if (!(slot_q.source == SrcMidi && slot_q.gate)) begin
          slot_d = '{source: SrcCv, gate: 1'b1, key_held: 1'b0, age: cmd_i.age
                     + 32'(rank_i) + 32'd1, note: '0, channel: '0, velocity: '0,
                     poly: '0};
          started_o = 1'b1;
        end
        OP_CV_FALL: if (slot_q.source == SrcCv) slot_d.gate = 1'b0;
        OP_CLEAR: if (cmd_i.target == idx_i && !slot_q.gate) slot_d = '0;
        OP_START: if (cmd_i.target == idx_i) begin
          slot_d = '{source: SrcMidi, gate: 1'b1, key_held: 1'b1,
                     age: cmd_i.age + 32'd1, note: cmd_i.note,
                     channel: cmd_i.channel, velocity: cmd_i.data, poly: '0};
          started_o = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) slot_q <= '0;
    else         slot_q <= slot_d;
  end

  assign slot_o = slot_q;
endmodule
`default_nettype wire

FILE: rtl/midi_voice_allocator.sv
// Top level of the MIDI voice allocator: control sequencer, channel state,
// voice cell row and record emitter. Depends on mva_pkg and mva_cell.
// Sequence: accept, decode, note-on search over the slot modes, apply, then a record
// scan of the active slots, held by output stalls. One request at a time. Reset
// resets slots, control registers and channel state (pitch bend to centre).
`default_nettype none
module midi_voice_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // status_byte[7:0], first_data[14:8], second_data[21:15], gate_level[22],
  // finished_voice[25:23]
  input  logic [31:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // voice_index[2:0], voice_source[4:3], voice_gate[5], started[6],
  // note_number[13:7], midi_channel[17:14], velocity[24:18],
  // poly_pressure[31:25], channel_pressure[38:32], mod_wheel[45:39],
  // pitch_bend[59:46]
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [4:0]  cfg_wdata_i
);
  import mva_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001, ST_DEC = 5'b00010, ST_SRCH = 5'b00100,
    ST_APPLY = 5'b01000, ST_EMIT = 5'b10000
  } state_e;

  typedef struct packed {
    logic [1:0]  source;
    logic        gate;
    logic [6:0]  note;
    logic [3:0]  channel;
    logic [6:0]  velocity;
    logic [6:0]  poly;
    logic [6:0]  pres;
    logic [6:0]  wheel;
    logic [13:0] bend;
  } rec_t;

  state_e state_q, state_d;
  logic [4:0]  chsel_q;
  logic [3:0]  voices_q;
  logic [25:0] in_q;
  logic [1:0]  kind_q;
  logic [31:0] age_q;
  logic        cvprev_q;
  logic [NumChannels-1:0] sus_q;
  logic [6:0]  wheel_q [NumChannels];
  logic [6:0]  pres_q  [NumChannels];
  logic [13:0] bend_q  [NumChannels];
  cmd_t        cmd_q;
  logic [1:0]  mode_q;
  logic [VoiceW-1:0] scan_q;
  logic [NumVoices-1:0] started_q;
  rec_t        before_q [NumVoices];
  logic        ovalid_q, olast_q;
  logic [63:0] odata_q;

  logic [CntW-1:0] n;
  logic [NumVoices-1:0] act, started;
  logic        found [NumVoices+1];
  logic [31:0] bage  [NumVoices+1];
  logic [VoiceW-1:0] bidx [NumVoices+1];
  logic [CntW-1:0] rank [NumVoices+1];
  slot_t       slot [NumVoices];
  logic        apply;

  wire [1:0] kind = kind_q;
  wire [3:0] msg  = in_q[7:4];
  wire [3:0] ch   = in_q[3:0];
  wire [6:0] d1   = in_q[14:8];
  wire [6:0] d2   = in_q[21:15];
  wire       gl   = in_q[22];
  wire [2:0] fv   = in_q[25:23];

  always_comb begin
    if (voices_q == 4'd0)                  n = CntW'(1);
    else if ({28'd0, voices_q} > MaxActive) n = CntW'(MaxActive);
    else                                   n = CntW'(voices_q);
  end

  for (genvar i = 0; i < NumVoices; i++) begin : g_cell
    assign act[i] = CntW'(i) < n;
    mva_cell u_cell (
      .clk_i, .rst_ni, .idx_i(VoiceW'(i)), .active_i(act[i]), .cmd_i(cmd_q),
      .apply_i(apply), .mode_i(mode_q), .found_i(found[i]),
      .best_age_i(bage[i]), .best_idx_i(bidx[i]), .rank_i(rank[i]),
      .found_o(found[i+1]), .best_age_o(bage[i+1]), .best_idx_o(bidx[i+1]),
      .rank_o(rank[i+1]), .slot_o(slot[i]), .started_o(started[i]));
  end
  assign found[0] = 1'b0;
  assign bage[0]  = '0;
  assign bidx[0]  = '0;
  assign rank[0]  = '0;

  function automatic rec_t rec_of(slot_t s, logic [6:0] p, logic [6:0] w,
                                  logic [13:0] b);
    rec_t r;
    logic m;
    m = s.source == SrcMidi;
    r.source = s.source;  r.gate = s.gate;
    r.note = m ? s.note : '0;  r.channel = m ? s.channel : '0;
    r.velocity = m ? s.velocity : '0;  r.poly = m ? s.poly : '0;
    r.pres = m ? p : '0;  r.wheel = m ? w : '0;  r.bend = m ? b : BendCentre;
    return r;
  endfunction

  logic [VoiceW-1:0] si;
  rec_t now_rec;
  assign si = scan_q;
  assign now_rec = rec_of(slot[si], pres_q[slot[si].channel],
                          wheel_q[slot[si].channel], bend_q[slot[si].channel]);

  logic chan_ok;
  assign chan_ok = chsel_q == 5'd0 || {1'b0, ch} == chsel_q - 5'd1;
  assign apply = state_q == ST_APPLY;
  assign s_axis_tready = state_q == ST_IDLE;

  logic [CntW:0] rise_cnt;
  always_comb begin
    rise_cnt = '0;
    for (int i = 0; i < NumVoices; i++)
      if (act[i] && !(slot[i].source == SrcMidi && slot[i].gate))
        rise_cnt = rise_cnt + (CntW+1)'(1);
  end

  op_e dec_op;
  always_comb begin
    dec_op = OP_NONE;
    if (kind == KindMidi && chan_ok) begin
      if (msg == MsgNoteOn && d2 != '0) dec_op = OP_START;
      else if (msg == MsgNoteOff || msg == MsgNoteOn) dec_op = OP_NOTE_OFF;
      else if (msg == MsgPoly) dec_op = OP_POLY;
      else if (msg == MsgCtrl && d1 == CtrlSustain && sus_q[ch] && !d2[6])
        dec_op = OP_SUS_REL;
    end else if (kind == KindGate) begin
      if (gl && !cvprev_q) dec_op = OP_CV_RISE;
      else if (!gl && cvprev_q) dec_op = OP_CV_FALL;
    end else if (kind == KindFinish && {1'b0, fv} < n) begin
      dec_op = OP_CLEAR;
    end
  end

  logic last_scan, emit_now, obusy, emit_fire;
  assign last_scan = {1'b0, scan_q} == CntW'(n - CntW'(1));
  assign obusy     = ovalid_q && !m_axis_tready;
  assign emit_now  = started_q[si] || now_rec != before_q[si];
  assign emit_fire = state_q == ST_EMIT && !obusy && emit_now;

  logic later;
  always_comb begin
    later = 1'b0;
    for (int i = 0; i < NumVoices; i++)
      if (VoiceW'(i) > si && act[i] &&
          (started_q[i] || rec_of(slot[i], pres_q[slot[i].channel],
           wheel_q[slot[i].channel], bend_q[slot[i].channel]) != before_q[i]))
        later = 1'b1;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_DEC;
      ST_DEC:   state_d = (kind == KindMidi && msg == MsgNoteOn && d2 != '0
                           && chan_ok) ? ST_SRCH : ST_APPLY;
      ST_SRCH:  if (found[NumVoices] || mode_q == 2'd3) state_d = ST_APPLY;
      ST_APPLY: state_d = ST_EMIT;
      ST_EMIT:  if (!obusy && last_scan) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;  chsel_q <= '0;  voices_q <= 4'd4;  age_q <= '0;
      cvprev_q <= 1'b0;  sus_q <= '0;  mode_q <= '0;  scan_q <= '0;
      started_q <= '0;  ovalid_q <= 1'b0;  olast_q <= 1'b0;
      cmd_q <= '{op: OP_NONE, default: '0};
      for (int c = 0; c < NumChannels; c++) begin
        wheel_q[c] <= '0;  pres_q[c] <= '0;  bend_q[c] <= BendCentre;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_addr_i == RegChanSel) chsel_q <= cfg_wdata_i;
        else                         voices_q <= cfg_wdata_i[3:0];
      end
      if (emit_fire) ovalid_q <= 1'b1;
      else if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (s_axis_tvalid) begin
          in_q   <= s_axis_tdata[25:0];
          kind_q <= s_axis_tuser;
        end
        ST_DEC: begin
          for (int i = 0; i < NumVoices; i++)
            before_q[i] <= rec_of(slot[i], pres_q[slot[i].channel],
                                  wheel_q[slot[i].channel], bend_q[slot[i].channel]);
          mode_q <= '0;
          cmd_q <= '{op: dec_op, target: VoiceW'(fv), channel: ch, note: d1,
                     data: d2, sustain: sus_q[ch], age: age_q};
          if (kind == KindMidi && chan_ok) begin
            if (msg == MsgCtrl && d1 == CtrlWheel) wheel_q[ch] <= d2;
            else if (msg == MsgCtrl && d1 == CtrlSustain) sus_q[ch] <= d2[6];
            else if (msg == MsgChanPres) pres_q[ch] <= d1;
            else if (msg == MsgBend) bend_q[ch] <= {d2, d1};
          end else if (kind == KindGate) begin
            cvprev_q <= gl;
            if (gl && !cvprev_q) age_q <= age_q + 32'(rise_cnt);
          end
        end
        ST_SRCH: begin
          if (found[NumVoices]) begin
            cmd_q.target <= bidx[NumVoices];
            age_q <= age_q + 32'd1;
          end else if (mode_q == 2'd3) cmd_q.op <= OP_NONE;
          mode_q <= mode_q + 2'd1;
        end
        ST_APPLY: begin
          started_q <= started;
          scan_q <= '0;
        end
        ST_EMIT: if (!obusy) begin
          if (emit_now) begin
            olast_q  <= !later;
            odata_q  <= {4'd0, now_rec.bend, now_rec.wheel, now_rec.pres,
                         now_rec.poly, now_rec.velocity, now_rec.channel,
                         now_rec.note, started_q[si], now_rec.gate,
                         now_rec.source, 3'(si)};
          end
          if (!last_scan) scan_q <= scan_q + VoiceW'(1);
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;
endmodule
`default_nettype wire
